>>> rtl/core/atc_pkg.sv
// Shared types and constants for the tilt and temperature conversion block.
`timescale 1ns / 1ps
`default_nettype none
package atc_pkg;

    localparam int SQRT_CELLS   = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int ANGLE_FRAC   = 24;

    localparam logic [2:0]  REG_TEMP_OFFSET = 3'd0;
    localparam logic signed [15:0] TEMP_OFFSET_RST = -16'sd1600;
    localparam logic signed [17:0] TEMP_BIAS = 18'sd12410;
    localparam logic [8:0]  TEMP_DIV  = 9'd340;
    localparam logic [25:0] TEMP_HALF = 26'd170;
    localparam logic [24:0] TEMP_RECIP = 25'd25264513;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
        30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
        30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
        30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
        30'd115, 30'd57, 30'd29, 30'd14, 30'd7
    };

    typedef struct packed {
        logic [31:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [32:0] z;
    } cordic_lane_t;

    typedef struct packed {
        logic        zero;
        logic        neg_p;
        logic        nz_p;
        logic        sz_p;
        logic        neg_r;
        logic        nz_r;
        logic        sz_r;
        logic [15:0] abs_x;
        logic [15:0] abs_y;
        logic [16:0] temp;
    } side_t;

endpackage
`default_nettype wire

>>> rtl/core/accel_tilt_and_temp_conversion.sv
// Top level: pitch, roll and temperature from one raw accelerometer beat.
//
//  channel | direction | handshake            | payload
//  in      | receive   | in_valid / in_stall  | accel_x, accel_y, accel_z, temp_raw
//  out     | send      | out_valid / out_stall| pitch_deg, roll_deg, temp_celsius, zero_vector
//  cfg     | APB slave | psel/penable/pready  | temp_offset at byte address 0
//
// One beat per cycle while out_stall does not hold the pipeline; the path runs through 5 front stages
// (squares, temperature divide by 340), 32 square root cells, 28 CORDIC cells and the output register.
// Reset clears all valid bits and loads temp_offset with -1600.
// The whole pipeline holds while a result waits under out_stall; in_stall follows it.
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_and_temp_conversion
    import atc_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] temp_raw,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      pitch_deg,
    output logic signed [15:0]      roll_deg,
    output logic signed [16:0]      temp_celsius,
    output logic                    zero_vector,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int RND_SHIFT = ANGLE_FRAC - FRAC_BITS;
    localparam logic signed [33:0] RND_HALF = 34'sd1 <<< (RND_SHIFT - 1);
    localparam logic signed [33:0] FULL = 34'sd90 <<< FRAC_BITS;

    typedef struct packed {
        logic [31:0] sum_p;
        logic [31:0] sum_r;
        logic [15:0] abs_x;
        logic [15:0] abs_y;
        logic        neg_x;
        logic        neg_y;
        logic        zero;
        logic        tneg;
    } front_t;

    logic adv;
    logic signed [15:0] temp_offset_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TEMP_OFFSET[2]);
    assign prdata = (paddr[2] == REG_TEMP_OFFSET[2]) ?
                    {{16{temp_offset_reg[15]}}, temp_offset_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_offset_reg <= TEMP_OFFSET_RST;
        end
        else if (cfg_wr)
        begin
            temp_offset_reg <= pwdata[15:0];
        end
    end

    // front end
    logic signed [31:0] sq_x, sq_y, sq_z;
    logic signed [17:0] t_sum;
    front_t f1_next;
    logic [16:0] tabs_next;

    always_comb
    begin
        sq_x  = accel_x * accel_x;
        sq_y  = accel_y * accel_y;
        sq_z  = accel_z * accel_z;
        t_sum = 18'(temp_raw) + 18'(temp_offset_reg) + TEMP_BIAS;
        f1_next.sum_p = $unsigned(sq_y) + $unsigned(sq_z);
        f1_next.sum_r = $unsigned(sq_x) + $unsigned(sq_z);
        f1_next.abs_x = accel_x[15] ? 16'(-accel_x) : accel_x;
        f1_next.abs_y = accel_y[15] ? 16'(-accel_y) : accel_y;
        f1_next.neg_x = accel_x[15];
        f1_next.neg_y = accel_y[15];
        f1_next.zero  = (accel_x == 16'sd0) && (accel_y == 16'sd0) && (accel_z == 16'sd0);
        f1_next.tneg  = t_sum[17];
        tabs_next     = t_sum[17] ? 17'(-t_sum) : t_sum[16:0];
    end

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    front_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    logic [16:0] tabs1_reg, tabs2_reg;
    logic [7:0]  qa_est2_reg, qa3_reg, qa4_reg;
    logic [8:0]  ra3_reg;
    logic [25:0] n2_4_reg;
    logic [16:0] q2_est4_reg;
    logic [16:0] temp5_reg;

    logic [41:0] prod_a;
    logic [16:0] r_a;
    logic        ge_a;
    logic [25:0] n2_next;
    logic [50:0] prod_b;
    logic [25:0] r_b;
    logic [16:0] q2_b;
    logic [24:0] mag_b;
    logic [16:0] temp_next;

    always_comb
    begin
        prod_a    = 42'(tabs1_reg) * 42'(TEMP_RECIP);
        r_a       = tabs2_reg - 17'(qa_est2_reg * TEMP_DIV);
        ge_a      = r_a >= 17'(TEMP_DIV);
        n2_next   = (26'(ra3_reg) << FRAC_BITS) + TEMP_HALF;
        prod_b    = 51'(n2_next) * 51'(TEMP_RECIP);
        r_b       = n2_4_reg - 26'(q2_est4_reg * TEMP_DIV);
        q2_b      = q2_est4_reg + 17'(r_b >= 26'(TEMP_DIV));
        mag_b     = (25'(qa4_reg) << FRAC_BITS) + 25'(q2_b);
        temp_next = f4_reg.tneg ? 17'(-mag_b) : mag_b[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg      <= f1_next;
            tabs1_reg   <= tabs_next;
            f2_reg      <= f1_reg;
            tabs2_reg   <= tabs1_reg;
            qa_est2_reg <= prod_a[40:33];
            f3_reg      <= f2_reg;
            qa3_reg     <= qa_est2_reg + 8'(ge_a);
            ra3_reg     <= ge_a ? 9'(r_a - 17'(TEMP_DIV)) : r_a[8:0];
            f4_reg      <= f3_reg;
            qa4_reg     <= qa3_reg;
            n2_4_reg    <= n2_next;
            q2_est4_reg <= prod_b[49:33];
            f5_reg      <= f4_reg;
            temp5_reg   <= temp_next;
        end
    end

    // square root row
    logic       sq_v    [SQRT_CELLS+1];
    sqrt_lane_t sq_p    [SQRT_CELLS+1];
    sqrt_lane_t sq_r    [SQRT_CELLS+1];
    side_t      sq_side [SQRT_CELLS+1];

    always_comb
    begin
        sq_v[0]          = v5_reg;
        sq_p[0].rad      = f5_reg.sum_p;
        sq_p[0].rem      = 34'd0;
        sq_p[0].root     = 32'd0;
        sq_r[0].rad      = f5_reg.sum_r;
        sq_r[0].rem      = 34'd0;
        sq_r[0].root     = 32'd0;
        sq_side[0].zero  = f5_reg.zero;
        sq_side[0].neg_p = f5_reg.neg_x;
        sq_side[0].nz_p  = f5_reg.abs_x != 16'd0;
        sq_side[0].sz_p  = f5_reg.sum_p == 32'd0;
        sq_side[0].neg_r = f5_reg.neg_y;
        sq_side[0].nz_r  = f5_reg.abs_y != 16'd0;
        sq_side[0].sz_r  = f5_reg.sum_r == 32'd0;
        sq_side[0].abs_x = f5_reg.abs_x;
        sq_side[0].abs_y = f5_reg.abs_y;
        sq_side[0].temp  = temp5_reg;
    end

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        atc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sq_v[i]),
            .in_p      (sq_p[i]),
            .in_r      (sq_r[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_p     (sq_p[i+1]),
            .out_r     (sq_r[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // CORDIC row
    logic         cr_v    [CORDIC_STEPS+1];
    cordic_lane_t cr_p    [CORDIC_STEPS+1];
    cordic_lane_t cr_r    [CORDIC_STEPS+1];
    side_t        cr_side [CORDIC_STEPS+1];

    always_comb
    begin
        cr_v[0]    = sq_v[SQRT_CELLS];
        cr_side[0] = sq_side[SQRT_CELLS];
        cr_p[0].x  = $signed({3'b000, sq_p[SQRT_CELLS].root});
        cr_p[0].y  = $signed({3'b000, sq_side[SQRT_CELLS].abs_x, 16'd0});
        cr_p[0].z  = 33'sd0;
        cr_r[0].x  = $signed({3'b000, sq_r[SQRT_CELLS].root});
        cr_r[0].y  = $signed({3'b000, sq_side[SQRT_CELLS].abs_y, 16'd0});
        cr_r[0].z  = 33'sd0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        atc_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (cr_v[i]),
            .in_p      (cr_p[i]),
            .in_r      (cr_r[i]),
            .in_side   (cr_side[i]),
            .out_valid (cr_v[i+1]),
            .out_p     (cr_p[i+1]),
            .out_r     (cr_r[i+1]),
            .out_side  (cr_side[i+1])
        );
    end

    // round, clamp, sign
    function automatic logic [15:0] finish(input logic signed [32:0] z,
                                           input logic neg, input logic nz,
                                           input logic sz);
        logic signed [33:0] q;
        logic signed [33:0] qc;
        q  = (34'(z) + RND_HALF) >>> RND_SHIFT;
        qc = (q < 34'sd0) ? 34'sd0 : ((q > FULL) ? FULL : q);
        if (sz)
        begin
            qc = FULL;
        end
        if (!nz)
        begin
            qc = 34'sd0;
        end
        return neg ? 16'(-qc) : qc[15:0];
    endfunction

    side_t fin_side;
    logic  out_valid_reg;
    logic signed [15:0] pitch_reg, roll_reg;
    logic signed [16:0] temp_reg;
    logic  zero_reg;

    assign fin_side = cr_side[CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cr_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= finish(cr_p[CORDIC_STEPS].z, fin_side.neg_p, fin_side.nz_p,
                                fin_side.sz_p);
            roll_reg  <= finish(cr_r[CORDIC_STEPS].z, fin_side.neg_r, fin_side.nz_r,
                                fin_side.sz_r);
            temp_reg  <= fin_side.temp;
            zero_reg  <= fin_side.zero;
        end
    end

    assign adv          = !(out_valid_reg && out_stall);
    assign in_stall     = !adv;
    assign out_valid    = out_valid_reg;
    assign pitch_deg    = pitch_reg;
    assign roll_deg     = roll_reg;
    assign temp_celsius = temp_reg;
    assign zero_vector  = zero_reg;

    a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_vector) |-> (pitch_deg == 16'sd0 && roll_deg == 16'sd0))
        else $error("angles not zero for zero vector");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (temp_offset_reg == $past(pwdata[15:0])))
        else $error("temp_offset write lost");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v5_reg) && $stable(temp5_reg))
        else $error("front stage moved during stall");

endmodule
`default_nettype wire

>>> rtl/core/atc_sqrt_cell.sv
// One digit step of the square root row, two lanes plus sideband.
`timescale 1ns / 1ps
`default_nettype none
module atc_sqrt_cell
    import atc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire logic       in_valid,
    input  wire sqrt_lane_t in_p,
    input  wire sqrt_lane_t in_r,
    input  wire side_t      in_side,
    output logic            out_valid,
    output sqrt_lane_t      out_p,
    output sqrt_lane_t      out_r,
    output side_t           out_side
);

    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t l);
        logic [35:0] cur;
        logic [35:0] trial;
        logic        ge;
        sqrt_lane_t  o;
        cur   = {l.rem, l.rad[31:30]};
        trial = {2'b00, l.root, 2'b01};
        ge    = cur >= trial;
        o.rad  = {l.rad[29:0], 2'b00};
        o.rem  = ge ? 34'(cur - trial) : cur[33:0];
        o.root = {l.root[30:0], ge};
        return o;
    endfunction

    logic valid_reg;
    sqrt_lane_t p_reg, p_next, r_reg, r_next;
    side_t side_reg;

    always_comb
    begin
        p_next = sqrt_step(in_p);
        r_next = sqrt_step(in_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= p_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_p     = p_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

>>> rtl/core/atc_cordic_cell.sv
// One vectoring rotation of the CORDIC row, two lanes plus sideband.
`timescale 1ns / 1ps
`default_nettype none
module atc_cordic_cell
    import atc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire cordic_lane_t in_p,
    input  wire cordic_lane_t in_r,
    input  wire side_t        in_side,
    output logic              out_valid,
    output cordic_lane_t      out_p,
    output cordic_lane_t      out_r,
    output side_t             out_side
);

    localparam logic signed [32:0] ATAN = $signed({3'b000, ATAN_TAB[STEP]});

    function automatic cordic_lane_t rotate(input cordic_lane_t l);
        logic signed [34:0] dx;
        logic signed [34:0] dy;
        cordic_lane_t       o;
        dx = l.y >>> STEP;
        dy = l.x >>> STEP;
        if (l.y > 35'sd0)
        begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.z = l.z + ATAN;
        end
        else
        begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.z = l.z - ATAN;
        end
        return o;
    endfunction

    logic valid_reg;
    cordic_lane_t p_reg, p_next, r_reg, r_next;
    side_t side_reg;

    always_comb
    begin
        p_next = rotate(in_p);
        r_next = rotate(in_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= p_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_p     = p_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

>>> bench/accel_tilt_and_temp_conversion_test.sv
// Testbench for the tilt and temperature conversion block: directed and random beats, back pressure and offset writes.
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_and_temp_conversion_test;
    import atc_pkg::*;

    localparam int FRAC = 8;
    localparam int PIPE_LAT = 66;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [16:0] temp;
        logic               zero;
    } tilt_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] accel_x = '0;
    logic signed [15:0] accel_y = '0;
    logic signed [15:0] accel_z = '0;
    logic signed [15:0] temp_raw = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic signed [16:0] temp_celsius;
    logic zero_vector;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    accel_tilt_and_temp_conversion u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .temp_raw(temp_raw),
        .out_valid(out_valid), .out_stall(out_stall),
        .pitch_deg(pitch_deg), .roll_deg(roll_deg),
        .temp_celsius(temp_celsius), .zero_vector(zero_vector),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tilt_result_t pending_results[$];
    logic signed [15:0] cur_offset;
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit busy_out = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint tilt_angle(int num, longint unsigned sumsq);
        longint full;
        longint q;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        full = 90 * (64'sd1 << FRAC);
        z = 0;
        if (num == 0)
            return 0;
        if (sumsq == 0)
            q = full;
        else
        begin
            x = longint'(int_sqrt(sumsq << 32));
            y = longint'(num < 0 ? -num : num) * 65536;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_TAB[i]);
                end
            end
            q = (z + (64'sd1 << (ANGLE_FRAC - FRAC - 1))) >>> (ANGLE_FRAC - FRAC);
            if (q < 0)
                q = 0;
            if (q > full)
                q = full;
        end
        return num < 0 ? -q : q;
    endfunction

    function automatic tilt_result_t convert_sample(logic signed [15:0] ax,
                                                    logic signed [15:0] ay,
                                                    logic signed [15:0] az,
                                                    logic signed [15:0] tr);
        tilt_result_t r;
        longint unsigned sx;
        longint unsigned sy;
        longint unsigned sz;
        longint num;
        longint t;
        sx = longint'(ax) * longint'(ax);
        sy = longint'(ay) * longint'(ay);
        sz = longint'(az) * longint'(az);
        r.zero = (ax == 0 && ay == 0 && az == 0);
        r.pitch = '0;
        r.roll = '0;
        if (!r.zero)
        begin
            r.pitch = 16'(tilt_angle(int'(ax), sy + sz));
            r.roll = 16'(tilt_angle(int'(ay), sx + sz));
        end
        num = (longint'(tr) + longint'(cur_offset) + 12410) * (64'sd1 << FRAC);
        if (num >= 0)
            t = (num + 170) / 340;
        else
            t = -((-num + 170) / 340);
        r.temp = 17'(t);
        return r;
    endfunction

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, logic signed [15:0] tr,
                               bit gaps);
        int gap;
        if (gaps)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        accel_x <= ax;
        accel_y <= ay;
        accel_z <= az;
        temp_raw <= tr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(convert_sample(ax, ay, az, tr));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_offset(logic signed [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TEMP_OFFSET;
        pwdata <= {{16{value[15]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_offset = value;
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] ext[6];
        ext = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
        send_sample(0, 0, 0, 0, 0);
        send_sample(16'sh8000, 0, 0, 16'sh8000, 0);
        send_sample(16'sh7fff, 0, 0, 16'sh7fff, 0);
        send_sample(0, 16'sh8000, 0, 0, 0);
        send_sample(0, 16'sh7fff, 0, 0, 0);
        send_sample(0, 0, 16'sh8000, 0, 0);
        send_sample(0, 0, 16'sh7fff, -16'sd1, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_sample(16'sd16384, 0, 16'sd16384, 16'sd1600, 0);
        send_sample(-16'sd1, 16'sd1, 0, -16'sd10810, 0);
        for (int i = 0; i < 6; i++)
            send_sample(ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 3) % 6], 0);
        drain_results();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_sample(rand_axis(), rand_axis(), rand_axis(), 16'($urandom), 1);
        drain_results();
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        for (int i = 0; i < 120; i++)
            send_sample(rand_axis(), rand_axis(), rand_axis(), 16'($urandom), 0);
        drain_results();
    endtask

    task automatic test_offsets();
        logic signed [15:0] offs[4];
        offs = '{16'sh8000, 16'sh7fff, 16'sd0, 16'($urandom)};
        for (int k = 0; k < 4; k++)
        begin
            write_offset(offs[k]);
            send_sample(0, 0, 0, 16'sh8000, 0);
            send_sample(0, 0, 0, 16'sh7fff, 0);
            test_random(60);
        end
        write_offset(TEMP_OFFSET_RST);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                tilt_result_t e;
                e = pending_results.pop_front();
                if (pitch_deg !== e.pitch)
                begin
                    $error("pitch_deg expected %0d got %0d", e.pitch, pitch_deg);
                    errors++;
                end
                if (roll_deg !== e.roll)
                begin
                    $error("roll_deg expected %0d got %0d", e.roll, roll_deg);
                    errors++;
                end
                if (temp_celsius !== e.temp)
                begin
                    $error("temp_celsius expected %0d got %0d", e.temp, temp_celsius);
                    errors++;
                end
                if (zero_vector !== e.zero)
                begin
                    $error("zero_vector expected %0d got %0d", e.zero, zero_vector);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int r;
        if (!busy_out && hold_off)
        begin
            out_stall <= 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
            out_stall <= 1'b0;
        end
        else if (!busy_out)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                out_stall <= 1'b0;
            else if (r < 97)
                out_stall <= 1'b1;
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        cur_offset = TEMP_OFFSET_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        busy_out = 1'b0;
        test_directed();
        test_random(565);
        test_back_pressure();
        test_offsets();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
